[hw/rtl/stl_pkg.sv]
`timescale 1ns / 1ps
package stl_pkg;

  // Counter widths, fixed by the token field widths
  localparam int OFFSET_BITS = 20;
  localparam int LINE_BITS   = 16;
  localparam int COLUMN_BITS = 16;
  localparam int LEN_BITS    = 16;

  localparam int KBUF_DEPTH = 6;
  localparam int KBUF_IDX   = $clog2(KBUF_DEPTH);
  localparam int KW_COUNT   = 5;

  // Scanner modes
  localparam logic [2:0] M_IDLE   = 3'd0;
  localparam logic [2:0] M_IDENT  = 3'd1;
  localparam logic [2:0] M_NUMBER = 3'd2;
  localparam logic [2:0] M_STRING = 3'd3;
  localparam logic [2:0] M_EQUALS = 3'd4;
  localparam logic [2:0] M_HALTED = 3'd5;

  // Token kinds
  localparam logic [2:0] K_EOF     = 3'd0;
  localparam logic [2:0] K_KEYWORD = 3'd1;
  localparam logic [2:0] K_IDENT   = 3'd2;
  localparam logic [2:0] K_NUMBER  = 3'd3;
  localparam logic [2:0] K_STRING  = 3'd4;
  localparam logic [2:0] K_DELIM   = 3'd5;
  localparam logic [2:0] K_OPER    = 3'd6;
  localparam logic [2:0] K_ERROR   = 3'd7;

  // Error kinds
  localparam logic E_UNKNOWN = 1'b0;
  localparam logic E_UNTERM  = 1'b1;

  // Request types
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_END  = 1'b1;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

  // Keyword table: int, if, else, while, return
  localparam logic [0:KW_COUNT-1][0:KBUF_DEPTH-1][7:0] KW_TEXT = '{
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00},
    '{"r", "e", "t", "u", "r", "n"}
  };
  localparam logic [0:KW_COUNT-1][2:0] KW_LEN = '{3'd3, 3'd2, 3'd4, 3'd5, 3'd6};

  typedef logic [KBUF_DEPTH-1:0][7:0] kbuf_t;

  typedef struct packed {
    logic [2:0]             mode;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] col;
    logic [OFFSET_BITS-1:0] off;
    logic [OFFSET_BITS-1:0] soff;
    logic [COLUMN_BITS-1:0] scol;
    logic [LEN_BITS-1:0]    len;
  } st_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] line;
    logic [15:0] column;
    logic [19:0] offset;
    logic [15:0] length;
    logic [2:0]  kw;
    logic [7:0]  symbol;
    logic        err;
    logic        last;
  } tok_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] idx;
  } kw_hit_t;

  localparam st_t ST_RESET = '{
    mode: M_IDLE,
    line: LINE_BITS'(1),
    col:  COLUMN_BITS'(1),
    off:  '0,
    soff: '0,
    scol: COLUMN_BITS'(1),
    len:  '0
  };

  function automatic logic is_space(logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_delim(logic [7:0] c);
    return c inside {"(", ")", "{", "}", ";", ","};
  endfunction

  function automatic logic is_oper(logic [7:0] c);
    return c inside {"=", "+", "-", "*", "/", "<", ">", "!"};
  endfunction

  // Move the position counters past one byte, all saturating
  function automatic st_t advance(st_t s, logic [7:0] c);
    st_t r;
    r = s;
    if (c == CH_NL) begin
      if (s.line != '1) r.line = s.line + 1'b1;
      r.col = COLUMN_BITS'(1);
    end else if (s.col != '1) begin
      r.col = s.col + 1'b1;
    end
    if (s.off != '1) r.off = s.off + 1'b1;
    return r;
  endfunction

  function automatic kw_hit_t kw_lookup(kbuf_t b, logic [LEN_BITS-1:0] len);
    kw_hit_t r;
    logic    eq;
    r = '0;
    for (int k = 0; k < KW_COUNT; k++) begin
      eq = (len == LEN_BITS'(KW_LEN[k]));
      for (int j = 0; j < KBUF_DEPTH; j++) begin
        if (j < int'(KW_LEN[k]) && b[j] != KW_TEXT[k][j]) eq = 1'b0;
      end
      if (eq && !r.hit) begin
        r.hit = 1'b1;
        r.idx = 3'(k);
      end
    end
    return r;
  endfunction

  function automatic tok_t make_tok(logic [2:0] kind, logic [LINE_BITS-1:0] line,
                                    logic [COLUMN_BITS-1:0] col,
                                    logic [OFFSET_BITS-1:0] off,
                                    logic [LEN_BITS-1:0] len, logic [2:0] kw,
                                    logic [7:0] sym, logic err);
    tok_t t;
    t.kind   = kind;
    t.line   = line;
    t.column = col;
    t.offset = off;
    t.length = len;
    t.kw     = kw;
    t.symbol = sym;
    t.err    = err;
    t.last   = 1'b1;
    return t;
  endfunction

endpackage

[hw/rtl/stl_req_if.sv]
`timescale 1ns / 1ps
interface stl_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] ch;

  modport source (output valid, output req_type, output ch, input ready);
  modport sink   (input valid, input req_type, input ch, output ready);
endinterface

[hw/rtl/stl_tok_if.sv]
`timescale 1ns / 1ps
interface stl_tok_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [15:0] token_line;
  logic [15:0] token_column;
  logic [19:0] token_offset;
  logic [15:0] token_length;
  logic [2:0]  keyword_index;
  logic [7:0]  symbol;
  logic        error_kind;
  logic        last_of_run;

  modport source (output valid, output token_kind, output token_line, output token_column,
                  output token_offset, output token_length, output keyword_index,
                  output symbol, output error_kind, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input token_line, input token_column,
                  input token_offset, input token_length, input keyword_index,
                  input symbol, input error_kind, input last_of_run, output ready);
endinterface

[hw/rtl/stl_step.sv]
`timescale 1ns / 1ps
module stl_step import stl_pkg::*; (
  input  st_t        st,
  input  kbuf_t      kbuf,
  input  logic       req_type,
  input  logic [7:0] ch,
  output st_t        st_next,
  output kbuf_t      kbuf_next,
  output logic [1:0] n_res,
  output tok_t       res0,
  output tok_t       res1
);

  st_t     s;
  kbuf_t   kb;
  tok_t    ta, tb;
  logic    va, vb;
  logic    fall;
  logic    endc;
  kw_hit_t kwl;

  assign endc = (req_type == REQ_END) || (ch == CH_NUL);
  assign kwl  = kw_lookup(kbuf, st.len);

  // ta: token closed by the current mode, tb: token started by this byte
  always_comb begin
    s    = st;
    kb   = kbuf;
    ta   = '0;
    tb   = '0;
    va   = 1'b0;
    vb   = 1'b0;
    fall = 1'b0;

    case (st.mode)
      M_HALTED: begin
        if (endc) s = ST_RESET;
      end
      M_IDENT: begin
        if (!endc && (is_alpha(ch) || is_digit(ch) || ch == CH_UNDER)) begin
          if (s.len < LEN_BITS'(KBUF_DEPTH)) kb[s.len[KBUF_IDX-1:0]] = ch;
          if (s.len != LEN_MAX) s.len = s.len + 1'b1;
          s = advance(s, ch);
        end else begin
          va = 1'b1;
          if (kwl.hit) ta = make_tok(K_KEYWORD, s.line, s.scol, s.soff, s.len,
                                     kwl.idx, 8'h00, 1'b0);
          else         ta = make_tok(K_IDENT, s.line, s.scol, s.soff, s.len,
                                     3'd0, 8'h00, 1'b0);
          s.mode = M_IDLE;
          fall   = 1'b1;
        end
      end
      M_NUMBER: begin
        if (!endc && is_digit(ch)) begin
          if (s.len < LEN_BITS'(KBUF_DEPTH)) kb[s.len[KBUF_IDX-1:0]] = ch;
          if (s.len != LEN_MAX) s.len = s.len + 1'b1;
          s = advance(s, ch);
        end else begin
          va     = 1'b1;
          ta     = make_tok(K_NUMBER, s.line, s.scol, s.soff, s.len, 3'd0, 8'h00, 1'b0);
          s.mode = M_IDLE;
          fall   = 1'b1;
        end
      end
      M_STRING: begin
        if (endc) begin
          va = 1'b1;
          ta = make_tok(K_ERROR, s.line, s.col, s.off, '0, 3'd0, 8'h00, E_UNTERM);
          s  = ST_RESET;
        end else begin
          s = advance(s, ch);
          if (ch == CH_QUOTE) begin
            va     = 1'b1;
            ta     = make_tok(K_STRING, s.line, s.scol, s.soff, s.len, 3'd0, 8'h00, 1'b0);
            s.mode = M_IDLE;
          end else if (s.len != LEN_MAX) begin
            s.len = s.len + 1'b1;
          end
        end
      end
      M_EQUALS: begin
        va     = 1'b1;
        s.mode = M_IDLE;
        if (!endc && ch == CH_EQ) begin
          s  = advance(s, ch);
          ta = make_tok(K_OPER, s.line, s.scol, s.soff, LEN_BITS'(2), 3'd0, 8'h00, 1'b0);
        end else begin
          ta   = make_tok(K_OPER, s.line, s.scol, s.soff, LEN_BITS'(1), 3'd0, CH_EQ, 1'b0);
          fall = 1'b1;
        end
      end
      default: begin
        s.mode = M_IDLE;
        fall   = 1'b1;
      end
    endcase

    if (fall) begin
      if (endc) begin
        vb = 1'b1;
        tb = make_tok(K_EOF, s.line, s.col, s.off, '0, 3'd0, 8'h00, 1'b0);
        s  = ST_RESET;
      end else if (is_space(ch)) begin
        s = advance(s, ch);
      end else if (is_alpha(ch) || is_digit(ch)) begin
        s.scol = s.col;
        s.soff = s.off;
        s.len  = LEN_BITS'(1);
        kb[0]  = ch;
        s      = advance(s, ch);
        s.mode = is_alpha(ch) ? M_IDENT : M_NUMBER;
      end else if (ch == CH_QUOTE) begin
        s.scol = s.col;
        s.len  = '0;
        s      = advance(s, ch);
        s.soff = s.off;
        s.mode = M_STRING;
      end else if (ch == CH_EQ) begin
        s.scol = s.col;
        s.soff = s.off;
        s.len  = '0;
        s      = advance(s, ch);
        s.mode = M_EQUALS;
      end else if (is_delim(ch) || is_oper(ch)) begin
        s.scol = s.col;
        s.soff = s.off;
        s.len  = '0;
        s      = advance(s, ch);
        vb     = 1'b1;
        tb     = make_tok(is_delim(ch) ? K_DELIM : K_OPER, s.line, s.scol, s.soff,
                          LEN_BITS'(1), 3'd0, ch, 1'b0);
      end else begin
        vb     = 1'b1;
        tb     = make_tok(K_ERROR, s.line, s.col, s.off, LEN_BITS'(1), 3'd0, ch, E_UNKNOWN);
        s.mode = M_HALTED;
      end
    end
  end

  always_comb begin
    st_next   = s;
    kbuf_next = kb;
    n_res     = 2'(va) + 2'(vb);
    res0      = va ? ta : tb;
    res0.last = !(va && vb);
    res1      = tb;
  end

endmodule

[hw/rtl/stl_fifo.sv]
`timescale 1ns / 1ps
module stl_fifo import stl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_n,
  input  tok_t       wdata0,
  input  tok_t       wdata1,
  input  logic       pop,
  output tok_t       rdata,
  output logic       nonempty,
  output logic       room
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  tok_t          mem [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [AW:0]   count;

  assign nonempty = (count != '0);
  assign room     = (count <= (AW+1)'(DEPTH - 2));
  assign rdata    = mem[rptr];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[wptr] <= wdata0;
    if (push_n == 2'd2) mem[wptr + 1'b1] <= wdata1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + AW'(push_n);
      if (pop) rptr <= rptr + 1'b1;
      count <= count + (AW+1)'(push_n) - (AW+1)'(pop);
    end
  end

endmodule

[hw/rtl/source_token_lexer_core.sv]
`timescale 1ns / 1ps
// Streaming source lexer.
// req (sink): one request per source byte (req_type 0, byte in ch) or an end
//   of source marker (req_type 1, or a zero byte). Accepted when valid and ready.
// tok (source): token records, in order; last_of_run marks the final token
//   caused by one request. A request gives zero, one or two tokens.
// A token is written into the token queue at the edge that accepted its
//   request and is offered on tok once it reaches the head of the queue.
// Throughput: one request per cycle while req.ready is high. The scanner
//   state updates once per byte; a request that closes one token and yields
//   another (two results) writes both at once into a four-entry token queue.
// req.ready is high while the queue has room for two tokens, so a stalled
//   receiver fills the queue and then holds off requests; nothing is dropped.
// Reset (rst, synchronous): scanner idle at line 1, column 1, offset 0, token
//   queue empty. End of source also returns the scanner to this state.
// After an unknown byte the scanner ignores bytes until end of source.
module source_token_lexer_core import stl_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  stl_req_if.sink       req,
  stl_tok_if.source     tok
);

  st_t        st, st_next;
  kbuf_t      kbuf, kbuf_next;
  logic [1:0] n_res;
  tok_t       res0, res1, head;
  logic       accept;
  logic       room, nonempty;

  assign req.ready = room;
  assign accept    = req.valid && room;

  // Per-byte scanner: next state and up to two tokens
  stl_step u_step (
    .st        (st),
    .kbuf      (kbuf),
    .req_type  (req.req_type),
    .ch        (req.ch),
    .st_next   (st_next),
    .kbuf_next (kbuf_next),
    .n_res     (n_res),
    .res0      (res0),
    .res1      (res1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_RESET;
    end else if (accept) begin
      st <= st_next;
    end
  end

  // keyword bytes: no reset, only entries written in the current word are read
  always_ff @(posedge clk) begin
    if (accept) kbuf <= kbuf_next;
  end

  stl_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push_n   (accept ? n_res : 2'd0),
    .wdata0   (res0),
    .wdata1   (res1),
    .pop      (tok.valid && tok.ready),
    .rdata    (head),
    .nonempty (nonempty),
    .room     (room)
  );

  assign tok.valid         = nonempty;
  assign tok.token_kind    = head.kind;
  assign tok.token_line    = head.line;
  assign tok.token_column  = head.column;
  assign tok.token_offset  = head.offset;
  assign tok.token_length  = head.length;
  assign tok.keyword_index = head.kw;
  assign tok.symbol        = head.symbol;
  assign tok.error_kind    = head.err;
  assign tok.last_of_run   = head.last;

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the streaming source lexer.
//
// Requests go in on req_bus one byte (or end marker) at a time. A behavioral
// lexer in this file follows every accepted request and queues the tokens it
// should produce. Tokens leaving on tok_bus are checked field by field against
// the head of that queue.
//
// Stimulus, in order:
//   - a short directed plan: end markers straight after reset, bad bytes,
//     a keyword, ==, a lone =, an unterminated string, ignored bytes after an
//     error. Rows whose token is obvious carry it typed in; the rest are
//     predicted.
//   - random sources, mostly well-formed token streams with random content,
//     some with an unknown byte or an open string, some pure noise.
//   - a stretch of random sources with no gaps on either side.
//   - more random sources.
// Both sides idle at random except during the no-gap stretch.
module tb;
  import stl_pkg::*;

  localparam int STALL_PCT    = 38;   // percent of cycles each side idles
  localparam int WATCHDOG     = 4000; // cycles with no handshake at all
  localparam int DRAIN_CYCLES = 20;   // quiet time after the last token
  localparam int RANDOM_ITEMS = 925;  // requests in the random part
  localparam int STEADY_ITEMS = 150;  // of those, sent with no gaps

  logic clk;
  logic rst;

  stl_req_if req_bus();
  stl_tok_if tok_bus();

  source_token_lexer_core uut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .tok(tok_bus)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------
  // Behavioral lexer
  // ---------------------------------------------------------------------
  logic [2:0]             lx_mode;
  logic [LINE_BITS-1:0]   lx_line;
  logic [COLUMN_BITS-1:0] lx_col;
  logic [OFFSET_BITS-1:0] lx_off;
  logic [OFFSET_BITS-1:0] lx_tok_off;  // where the open lexeme starts
  logic [COLUMN_BITS-1:0] lx_tok_col;
  logic [LEN_BITS-1:0]    lx_len;
  logic [7:0]             lx_word [6]; // first bytes of an identifier

  string kw_spell [5] = '{"int", "if", "else", "while", "return"};

  tok_t step_toks [2]; // tokens caused by the latest request
  int   step_count;
  tok_t tokens_due [$]; // tokens predicted but not yet seen on tok_bus

  bit gaps_on;
  int fails;
  int lex_items;   // requests accepted
  int tokens_seen;
  int quiet_cycles;
  tok_t head_tok;

  function automatic void lexer_clear();
    lx_mode    = M_IDLE;
    lx_line    = LINE_BITS'(1);
    lx_col     = COLUMN_BITS'(1);
    lx_off     = '0;
    lx_tok_off = '0;
    lx_tok_col = COLUMN_BITS'(1);
    lx_len     = '0;
  endfunction

  function automatic bit blank_ch(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit letter_ch(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic bit digit_ch(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic bit delim_ch(logic [7:0] c);
    case (c)
      "(", ")", "{", "}", ";", ",": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit oper_ch(logic [7:0] c);
    case (c)
      "=", "+", "-", "*", "/", "<", ">", "!": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Step the position past one byte; every counter sticks at all ones.
  function automatic void move_past(logic [7:0] c);
    if (c == CH_NL) begin
      if (lx_line != '1) lx_line++;
      lx_col = COLUMN_BITS'(1);
    end else if (lx_col != '1) begin
      lx_col++;
    end
    if (lx_off != '1) lx_off++;
  endfunction

  function automatic void mark_start();
    lx_tok_col = lx_col;
    lx_tok_off = lx_off;
    lx_len     = '0;
  endfunction

  function automatic void grow(logic [7:0] c);
    if (lx_len < 6) lx_word[lx_len[2:0]] = c;
    if (lx_len != LEN_MAX) lx_len++;
  endfunction

  // error_kind reads 0 (E_UNKNOWN) on every token that is not an error
  function automatic void put_tok(logic [2:0] kind, logic [15:0] line, logic [15:0] col,
                                  logic [19:0] off, logic [15:0] len, logic [2:0] kw,
                                  logic [7:0] sym, logic err);
    tok_t t;
    t.kind   = kind;
    t.line   = line;
    t.column = col;
    t.offset = off;
    t.length = len;
    t.kw     = kw;
    t.symbol = sym;
    t.err    = err;
    t.last   = 1'b1;
    if (step_count > 0) step_toks[step_count - 1].last = 1'b0;
    step_toks[step_count] = t;
    step_count++;
  endfunction

  // Identifier or keyword; only bytes already captured are compared
  function automatic void put_word();
    bit   hit;
    bit   same;
    logic [2:0] idx;
    hit = 1'b0;
    idx = 3'd0;
    for (int k = 0; k < 5; k++) begin
      same = (lx_len == LEN_BITS'(kw_spell[k].len()));
      for (int j = 0; j < kw_spell[k].len(); j++) begin
        if (same && lx_word[j] != kw_spell[k][j]) same = 1'b0;
      end
      if (same) begin
        hit = 1'b1;
        idx = 3'(k);
      end
    end
    put_tok(hit ? K_KEYWORD : K_IDENT, lx_line, lx_tok_col, lx_tok_off, lx_len,
            idx, 8'h00, E_UNKNOWN);
  endfunction

  // One request: a pending token is closed first, then the byte itself is handled
  function automatic void lex_step(logic rt, logic [7:0] c);
    logic fin;
    fin = (rt == REQ_END) || (c == CH_NUL);
    step_count = 0;
    case (lx_mode)
      M_HALTED: begin
        if (fin) lexer_clear();
        return;
      end
      M_IDENT: begin
        if (!fin && (letter_ch(c) || digit_ch(c) || c == CH_UNDER)) begin
          grow(c);
          move_past(c);
          return;
        end
        put_word();
        lx_mode = M_IDLE;
      end
      M_NUMBER: begin
        if (!fin && digit_ch(c)) begin
          grow(c);
          move_past(c);
          return;
        end
        put_tok(K_NUMBER, lx_line, lx_tok_col, lx_tok_off, lx_len, 3'd0, 8'h00, E_UNKNOWN);
        lx_mode = M_IDLE;
      end
      M_STRING: begin
        if (fin) begin
          put_tok(K_ERROR, lx_line, lx_col, lx_off, 16'd0, 3'd0, 8'h00, E_UNTERM);
          lexer_clear();
          return;
        end
        move_past(c);
        if (c == CH_QUOTE) begin
          put_tok(K_STRING, lx_line, lx_tok_col, lx_tok_off, lx_len, 3'd0, 8'h00, E_UNKNOWN);
          lx_mode = M_IDLE;
        end else if (lx_len != LEN_MAX) begin
          lx_len++;
        end
        return;
      end
      M_EQUALS: begin
        if (!fin && c == CH_EQ) begin
          move_past(c);
          put_tok(K_OPER, lx_line, lx_tok_col, lx_tok_off, 16'd2, 3'd0, 8'h00, E_UNKNOWN);
          lx_mode = M_IDLE;
          return;
        end
        put_tok(K_OPER, lx_line, lx_tok_col, lx_tok_off, 16'd1, 3'd0, CH_EQ, E_UNKNOWN);
        lx_mode = M_IDLE;
      end
      default: lx_mode = M_IDLE;
    endcase

    if (fin) begin
      put_tok(K_EOF, lx_line, lx_col, lx_off, 16'd0, 3'd0, 8'h00, E_UNKNOWN);
      lexer_clear();
      return;
    end
    if (blank_ch(c)) begin
      move_past(c);
    end else if (letter_ch(c)) begin
      mark_start();
      grow(c);
      move_past(c);
      lx_mode = M_IDENT;
    end else if (digit_ch(c)) begin
      mark_start();
      grow(c);
      move_past(c);
      lx_mode = M_NUMBER;
    end else if (c == CH_QUOTE) begin
      // string offset points past the opening quote
      mark_start();
      move_past(c);
      lx_tok_off = lx_off;
      lx_mode = M_STRING;
    end else if (delim_ch(c)) begin
      mark_start();
      move_past(c);
      put_tok(K_DELIM, lx_line, lx_tok_col, lx_tok_off, 16'd1, 3'd0, c, E_UNKNOWN);
    end else if (c == CH_EQ) begin
      // could still become ==
      mark_start();
      move_past(c);
      lx_mode = M_EQUALS;
    end else if (oper_ch(c)) begin
      mark_start();
      move_past(c);
      put_tok(K_OPER, lx_line, lx_tok_col, lx_tok_off, 16'd1, 3'd0, c, E_UNKNOWN);
    end else begin
      // unknown byte: report at the current position, then swallow until end
      put_tok(K_ERROR, lx_line, lx_col, lx_off, 16'd1, 3'd0, c, E_UNKNOWN);
      lx_mode = M_HALTED;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------
  // Returns at the edge that accepted the request, with the lexer stepped.
  task automatic send(logic rt, logic [7:0] c);
    while (gaps_on && $urandom_range(99) < STALL_PCT) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= rt;
    req_bus.ch       <= c;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    lex_items++;
    lex_step(rt, c);
  endtask

  task automatic queue_step();
    for (int i = 0; i < step_count; i++) tokens_due = {tokens_due, step_toks[i]};
  endtask

  task automatic feed(logic rt, logic [7:0] c);
    send(rt, c);
    queue_step();
  endtask

  task automatic feed_text(string s);
    for (int i = 0; i < s.len(); i++) feed(REQ_BYTE, s[i]);
  endtask

  // ---------------------------------------------------------------------
  // Random source pieces
  // ---------------------------------------------------------------------
  function automatic logic [7:0] rand_letter();
    if ($urandom_range(1)) return 8'($urandom_range(8'h7A, 8'h61));
    return 8'($urandom_range(8'h5A, 8'h41));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'($urandom_range(8'h39, 8'h30));
  endfunction

  function automatic logic [7:0] rand_word_char();
    int pick;
    pick = $urandom_range(9);
    if (pick < 6) return rand_letter();
    if (pick < 9) return rand_digit();
    return CH_UNDER;
  endfunction

  // anything but a quote or NUL: newlines and high bytes included
  function automatic logic [7:0] rand_string_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255, 1)); while (c == CH_QUOTE);
    return c;
  endfunction

  function automatic logic [7:0] rand_bad_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(255, 1));
    while (blank_ch(c) || letter_ch(c) || digit_ch(c) || delim_ch(c) || oper_ch(c) ||
           c == CH_QUOTE);
    return c;
  endfunction

  function automatic logic [7:0] rand_gap();
    case ($urandom_range(7))
      0: return 8'h09;
      1: return 8'h0B;
      2: return 8'h0C;
      3: return 8'h0D;
      4, 5: return CH_NL;
      default: return 8'h20;
    endcase
  endfunction

  task automatic feed_token();
    string delims;
    string opers;
    string word;
    int    pick;
    delims = "(){};,";
    opers  = "=+-*/<>!";
    pick   = $urandom_range(99);
    if (pick < 15) begin
      feed_text(kw_spell[$urandom_range(4)]);
    end else if (pick < 22) begin
      // near miss: keyword with one byte more or one byte less
      word = kw_spell[$urandom_range(4)];
      if ($urandom_range(1)) begin
        feed_text(word);
        feed(REQ_BYTE, rand_word_char());
      end else begin
        feed_text(word.substr(0, word.len() - 2));
      end
    end else if (pick < 36) begin
      feed(REQ_BYTE, rand_letter());
      repeat ($urandom_range(7)) feed(REQ_BYTE, rand_word_char());
    end else if (pick < 50) begin
      repeat ($urandom_range(6, 1)) feed(REQ_BYTE, rand_digit());
    end else if (pick < 60) begin
      feed(REQ_BYTE, CH_QUOTE);
      repeat ($urandom_range(8)) feed(REQ_BYTE, rand_string_char());
      feed(REQ_BYTE, CH_QUOTE);
    end else if (pick < 74) begin
      feed(REQ_BYTE, delims[$urandom_range(5)]);
    end else if (pick < 88) begin
      feed(REQ_BYTE, opers[$urandom_range(7)]);
    end else begin
      feed_text("==");
    end
  endtask

  // One whole source, closed by an end marker or a NUL byte.
  task automatic feed_source();
    int style;
    int count;
    int cut;
    style = $urandom_range(99);
    count = $urandom_range(16, 1);
    cut   = $urandom_range(count - 1);
    if (style < 8) begin
      // noise
      repeat ($urandom_range(20, 4)) feed(REQ_BYTE, 8'($urandom_range(255, 1)));
    end else begin
      for (int i = 0; i < count; i++) begin
        if ($urandom_range(2) != 0) feed(REQ_BYTE, rand_gap());
        feed_token();
        if (style >= 80 && style < 90 && i == cut) begin
          // unknown byte, then junk that must be swallowed
          feed(REQ_BYTE, rand_bad_byte());
          repeat ($urandom_range(5)) feed(REQ_BYTE, 8'($urandom_range(255, 1)));
          break;
        end
      end
      if (style >= 90) begin
        // string left open at end of source
        feed(REQ_BYTE, CH_QUOTE);
        repeat ($urandom_range(6)) feed(REQ_BYTE, rand_string_char());
      end
    end
    if ($urandom_range(4) == 0) feed(REQ_BYTE, CH_NUL);
    else feed(REQ_END, 8'($urandom_range(255)));
  endtask

  // Random sources with both sides running flat out
  task automatic feed_steady();
    int stop_at;
    gaps_on = 1'b0;
    stop_at = lex_items + STEADY_ITEMS;
    while (lex_items < stop_at) feed_source();
    gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------
  // Directed plan
  // ---------------------------------------------------------------------
  typedef struct {
    logic       rt;
    logic [7:0] c;
    bit         pinned;  // expectation typed in below
    bit         has_tok; // pinned rows give at most one token
    tok_t       want;
  } plan_row_t;

  plan_row_t plan [$];

  function automatic void add_row(plan_row_t r);
    plan = {plan, r};
  endfunction

  // token at the reset position: line 1, column 1, offset 0
  function automatic tok_t start_tok(logic [2:0] kind, logic [15:0] len, logic [7:0] sym);
    tok_t t;
    t.kind   = kind;
    t.line   = 16'd1;
    t.column = 16'd1;
    t.offset = 20'd0;
    t.length = len;
    t.kw     = 3'd0;
    t.symbol = sym;
    t.err    = E_UNKNOWN;
    t.last   = 1'b1;
    return t;
  endfunction

  function automatic plan_row_t pinned_row(logic rt, logic [7:0] c, bit has_tok, tok_t want);
    plan_row_t r;
    r.rt      = rt;
    r.c       = c;
    r.pinned  = 1'b1;
    r.has_tok = has_tok;
    r.want    = want;
    return r;
  endfunction

  function automatic plan_row_t free_row(logic rt, logic [7:0] c);
    plan_row_t r;
    r.rt      = rt;
    r.c       = c;
    r.pinned  = 1'b0;
    r.has_tok = 1'b0;
    r.want    = '0;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Token receiver and checker
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    tok_bus.ready <= !gaps_on || ($urandom_range(99) >= STALL_PCT);
  end

  function automatic void field_check(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && tok_bus.valid && tok_bus.ready) begin
      if (tokens_due.size() == 0) begin
        $error("token with nothing expected: kind %0d at line %0d column %0d",
               tok_bus.token_kind, tok_bus.token_line, tok_bus.token_column);
        fails++;
      end else begin
        head_tok = tokens_due.pop_front();
        tokens_seen++;
        field_check("token_kind", 32'(head_tok.kind), 32'(tok_bus.token_kind));
        field_check("token_line", 32'(head_tok.line), 32'(tok_bus.token_line));
        field_check("token_column", 32'(head_tok.column), 32'(tok_bus.token_column));
        field_check("token_offset", 32'(head_tok.offset), 32'(tok_bus.token_offset));
        field_check("token_length", 32'(head_tok.length), 32'(tok_bus.token_length));
        field_check("keyword_index", 32'(head_tok.kw), 32'(tok_bus.keyword_index));
        field_check("symbol", 32'(head_tok.symbol), 32'(tok_bus.symbol));
        field_check("error_kind", 32'(head_tok.err), 32'(tok_bus.error_kind));
        field_check("last_of_run", 32'(head_tok.last), 32'(tok_bus.last_of_run));
      end
    end
  end

  // Watchdog: any handshake on either side counts as progress
  always @(posedge clk) begin
    if (rst || (req_bus.valid && req_bus.ready) || (tok_bus.valid && tok_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG) begin
      $display("source_token_lexer_core: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int stop_at;
    rst              <= 1'b1;
    req_bus.valid    <= 1'b0;
    req_bus.req_type <= REQ_BYTE;
    req_bus.ch       <= CH_NUL;
    gaps_on      = 1'b1;
    fails        = 0;
    lex_items    = 0;
    tokens_seen  = 0;
    quiet_cycles = 0;
    lexer_clear();

    // end right after reset (marker and NUL), bad bytes at both ends of the
    // high range, swallowed bytes and a silent end while halted
    add_row(pinned_row(REQ_END, 8'h00, 1'b1, start_tok(K_EOF, 16'd0, 8'h00)));
    add_row(pinned_row(REQ_BYTE, CH_NUL, 1'b1, start_tok(K_EOF, 16'd0, 8'h00)));
    add_row(pinned_row(REQ_BYTE, 8'hFF, 1'b1, start_tok(K_ERROR, 16'd1, 8'hFF)));
    add_row(pinned_row(REQ_BYTE, "a", 1'b0, '0));
    add_row(pinned_row(REQ_END, 8'hFF, 1'b0, '0));
    add_row(pinned_row(REQ_BYTE, 8'h80, 1'b1, start_tok(K_ERROR, 16'd1, 8'h80)));
    add_row(pinned_row(REQ_BYTE, CH_NUL, 1'b0, '0));
    // keyword closed by a delimiter, ==, lone = closed by an operator
    add_row(free_row(REQ_BYTE, "i"));
    add_row(free_row(REQ_BYTE, "f"));
    add_row(free_row(REQ_BYTE, "("));
    add_row(free_row(REQ_BYTE, CH_EQ));
    add_row(free_row(REQ_BYTE, CH_EQ));
    add_row(free_row(REQ_BYTE, CH_EQ));
    add_row(free_row(REQ_BYTE, "!"));
    // string spanning a newline, then end inside it
    add_row(free_row(REQ_BYTE, CH_QUOTE));
    add_row(free_row(REQ_BYTE, CH_NL));
    add_row(free_row(REQ_BYTE, "x"));
    add_row(free_row(REQ_END, 8'h00));
    // number closed by DEL (unknown), then end while halted
    add_row(free_row(REQ_BYTE, "7"));
    add_row(free_row(REQ_BYTE, "9"));
    add_row(free_row(REQ_BYTE, 8'h7F));
    add_row(free_row(REQ_END, 8'h00));
    // identifier still open at a NUL end
    add_row(free_row(REQ_BYTE, 8'h20));
    add_row(free_row(REQ_BYTE, "a"));
    add_row(free_row(REQ_BYTE, CH_NUL));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      send(plan[i].rt, plan[i].c);
      if (!plan[i].pinned) begin
        queue_step();
      end else if (plan[i].has_tok) begin
        tokens_due = {tokens_due, plan[i].want};
      end
    end

    stop_at = lex_items + (RANDOM_ITEMS - STEADY_ITEMS) / 2;
    while (lex_items < stop_at) feed_source();
    feed_steady();
    stop_at = lex_items + (RANDOM_ITEMS - STEADY_ITEMS) - (RANDOM_ITEMS - STEADY_ITEMS) / 2;
    while (lex_items < stop_at) feed_source();

    req_bus.valid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests and checked %0d tokens: directed cases, random sources",
             lex_items, tokens_seen);
    $display("with bad bytes, open strings and noise, part of them with no idle cycles.");
    if (fails == 0 && tokens_due.size() == 0) begin
      $display("source_token_lexer_core: match");
    end else begin
      $display("source_token_lexer_core: mismatch");
    end
    $finish;
  end

endmodule

[source_token_lexer_core.f]
hw/rtl/stl_pkg.sv
hw/rtl/stl_req_if.sv
hw/rtl/stl_tok_if.sv
hw/rtl/stl_step.sv
hw/rtl/stl_fifo.sv
hw/rtl/source_token_lexer_core.sv
test/tb.sv
